>>> hdl/xtt_pkg.sv
// ----------------------------------------------------------------------------
// xtt_pkg
// Shared types, character codes and output packing for the XML tag tokenizer.
// ----------------------------------------------------------------------------
package xtt_pkg;

    // Default width of the byte position counter.
    localparam int POSITION_BITS_DEF = 32;

    // Widths of the stream payloads.
    localparam int IN_DATA_W  = 8;
    localparam int POS_OUT_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Bit positions of the result fields inside the output tdata.
    localparam int OB_ROLE_LO   = 0;
    localparam int OB_ROLE_HI   = 2;
    localparam int OB_KIND_LO   = 3;
    localparam int OB_KIND_HI   = 4;
    localparam int OB_TEXT_END  = 5;
    localparam int OB_NAME_END  = 6;
    localparam int OB_ANAME_END = 7;
    localparam int OB_VALUE_END = 8;
    localparam int OB_TAG_DONE  = 9;
    localparam int OB_SELF_CL   = 10;
    localparam int OB_POS_LO    = 11;
    localparam int OB_POS_HI    = 42;

    // Character codes with a meaning to the tokenizer.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Tokenizer states.
    typedef enum logic [3:0] {
        ST_DATA         = 4'd0,
        ST_TAG_OPEN     = 4'd1,
        ST_END_TAG_OPEN = 4'd2,
        ST_SKIP         = 4'd3,
        ST_TAG_NAME     = 4'd4,
        ST_SELF_CLOSE   = 4'd5,
        ST_BEFORE_ATTR  = 4'd6,
        ST_ATTR_NAME    = 4'd7,
        ST_AFTER_ATTR   = 4'd8,
        ST_BEFORE_VALUE = 4'd9,
        ST_VALUE_DQ     = 4'd10,
        ST_VALUE_SQ     = 4'd11,
        ST_AFTER_VALUE  = 4'd12
    } t_state;

    // Role of one byte.
    typedef enum logic [2:0] {
        ROLE_MARKUP = 3'd0,
        ROLE_TEXT   = 3'd1,
        ROLE_TAG    = 3'd2,
        ROLE_ANAME  = 3'd3,
        ROLE_AVALUE = 3'd4
    } t_role;

    // Kind of the tag being parsed.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Tokenizer context carried from one byte to the next.
    typedef struct packed {
        t_state state;
        logic   text_pending;
        t_kind  kind;
    } t_ctx;

    // Per-byte result, without the position.
    typedef struct packed {
        t_role role;
        t_kind kind;
        logic  text_end;
        logic  tag_name_end;
        logic  attr_name_end;
        logic  attr_value_end;
        logic  tag_done;
        logic  self_closing;
        logic  input_end;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

>>> hdl/xtt_step.sv
// ----------------------------------------------------------------------------
// xtt_step
// Next-context and result logic for one byte of the tag tokenizer.
// ----------------------------------------------------------------------------
module xtt_step
    import xtt_pkg::*;
(
    input  logic [7:0] i_char,
    input  t_ctx       i_ctx,
    output t_ctx       o_ctx,
    output t_result    o_res
);

    t_state  n_state;
    logic    n_pending;
    t_kind   n_kind;
    t_role   n_role;
    logic    n_t_end;
    logic    n_n_end;
    logic    n_a_end;
    logic    n_v_end;
    logic    n_done;
    logic    n_sc;

    // State transitions and per-state flags.
    always_comb begin
        n_state   = i_ctx.state;
        n_pending = i_ctx.text_pending;
        n_kind    = i_ctx.kind;
        n_role    = ROLE_MARKUP;
        n_t_end   = 1'b0;
        n_n_end   = 1'b0;
        n_a_end   = 1'b0;
        n_v_end   = 1'b0;
        n_done    = 1'b0;
        n_sc      = 1'b0;
        unique case (i_ctx.state)
            ST_TAG_OPEN: begin
                if (i_char == CH_BANG || i_char == CH_QUEST) begin
                    n_state = ST_SKIP;
                end else if (i_char == CH_SLASH) begin
                    n_state = ST_END_TAG_OPEN;
                end else if (is_letter(i_char)) begin
                    n_kind  = KIND_START;
                    n_role  = ROLE_TAG;
                    n_state = ST_TAG_NAME;
                end else begin
                    n_state = ST_DATA;
                end
            end
            ST_END_TAG_OPEN: begin
                if (is_letter(i_char)) begin
                    n_kind  = KIND_END;
                    n_role  = ROLE_TAG;
                    n_state = ST_TAG_NAME;
                end else if (i_char == CH_GT) begin
                    n_state = ST_DATA;
                end
            end
            ST_SKIP: begin
                if (i_char == CH_GT) begin
                    n_state = ST_DATA;
                end
            end
            ST_TAG_NAME: begin
                if (is_space(i_char)) begin
                    n_n_end = 1'b1;
                    n_state = ST_BEFORE_ATTR;
                end else if (i_char == CH_SLASH) begin
                    n_n_end = 1'b1;
                    n_state = ST_SELF_CLOSE;
                end else if (i_char == CH_GT) begin
                    n_n_end = 1'b1;
                    n_done  = 1'b1;
                end else begin
                    n_role = ROLE_TAG;
                end
            end
            ST_SELF_CLOSE: begin
                if (i_char == CH_GT) begin
                    n_done = 1'b1;
                    n_sc   = 1'b1;
                end else begin
                    n_state = ST_BEFORE_ATTR;
                end
            end
            ST_BEFORE_ATTR: begin
                if (i_char == CH_SLASH) begin
                    n_state = ST_SELF_CLOSE;
                end else if (i_char == CH_GT) begin
                    n_done = 1'b1;
                end else if (is_letter(i_char)) begin
                    n_role  = ROLE_ANAME;
                    n_state = ST_ATTR_NAME;
                end
            end
            ST_ATTR_NAME: begin
                if (is_space(i_char)) begin
                    n_a_end = 1'b1;
                    n_state = ST_AFTER_ATTR;
                end else if (i_char == CH_SLASH) begin
                    n_a_end = 1'b1;
                    n_state = ST_SELF_CLOSE;
                end else if (i_char == CH_EQ) begin
                    n_a_end = 1'b1;
                    n_state = ST_BEFORE_VALUE;
                end else if (i_char == CH_GT) begin
                    n_a_end = 1'b1;
                    n_done  = 1'b1;
                end else begin
                    n_role = ROLE_ANAME;
                end
            end
            ST_AFTER_ATTR: begin
                if (i_char == CH_SLASH) begin
                    n_state = ST_SELF_CLOSE;
                end else if (i_char == CH_EQ) begin
                    n_state = ST_BEFORE_VALUE;
                end else if (i_char == CH_GT) begin
                    n_done = 1'b1;
                end else if (is_letter(i_char)) begin
                    n_role  = ROLE_ANAME;
                    n_state = ST_ATTR_NAME;
                end
            end
            ST_BEFORE_VALUE: begin
                // An unquoted value byte is a parse error and drops back.
                if (is_space(i_char)) begin
                    n_state = ST_BEFORE_VALUE;
                end else if (i_char == CH_DQUOTE) begin
                    n_state = ST_VALUE_DQ;
                end else if (i_char == CH_SQUOTE) begin
                    n_state = ST_VALUE_SQ;
                end else if (i_char == CH_GT) begin
                    n_done = 1'b1;
                end else begin
                    n_state = ST_BEFORE_ATTR;
                end
            end
            ST_VALUE_DQ: begin
                if (i_char == CH_DQUOTE) begin
                    n_v_end = 1'b1;
                    n_state = ST_AFTER_VALUE;
                end else begin
                    n_role = ROLE_AVALUE;
                end
            end
            ST_VALUE_SQ: begin
                if (i_char == CH_SQUOTE) begin
                    n_v_end = 1'b1;
                    n_state = ST_AFTER_VALUE;
                end else begin
                    n_role = ROLE_AVALUE;
                end
            end
            ST_AFTER_VALUE: begin
                if (i_char == CH_SLASH) begin
                    n_state = ST_SELF_CLOSE;
                end else if (i_char == CH_GT) begin
                    n_done = 1'b1;
                end else begin
                    n_state = ST_BEFORE_ATTR;
                end
            end
            default: begin
                // Data state; unused codes behave the same way.
                if (i_char == CH_LT) begin
                    n_t_end   = i_ctx.text_pending;
                    n_pending = 1'b0;
                    n_state   = ST_TAG_OPEN;
                end else begin
                    n_role    = ROLE_TEXT;
                    n_pending = 1'b1;
                    n_state   = ST_DATA;
                end
            end
        endcase
    end

    // Result and next context, with end of input overriding everything.
    always_comb begin
        o_res.role           = n_role;
        o_res.kind           = n_kind;
        o_res.text_end       = n_t_end;
        o_res.tag_name_end   = n_n_end;
        o_res.attr_name_end  = n_a_end;
        o_res.attr_value_end = n_v_end;
        o_res.tag_done       = n_done;
        o_res.self_closing   = n_sc;
        o_res.input_end      = 1'b0;
        o_ctx.state          = n_done ? ST_DATA : n_state;
        o_ctx.text_pending   = n_pending;
        o_ctx.kind           = n_done ? KIND_NONE : n_kind;
        if (i_char == CH_NUL) begin
            o_res                = '0;
            o_res.role           = ROLE_MARKUP;
            o_res.kind           = KIND_NONE;
            o_res.text_end       = i_ctx.text_pending;
            o_res.input_end      = 1'b1;
            o_ctx.state          = ST_DATA;
            o_ctx.text_pending   = 1'b0;
            o_ctx.kind           = KIND_NONE;
        end
    end

endmodule

>>> hdl/xml_tag_tokenizer.sv
// ----------------------------------------------------------------------------
// xml_tag_tokenizer
// Byte-serial HTML-style tag tokenizer with stream input and output.
// ----------------------------------------------------------------------------
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the output takes results; tokenizer
// context updates in the same cycle that a byte moves to the result register.
// Reset: synchronous, active low; clears both valid flags, the context and the
// position counter. No clearing pass is needed.
// ----------------------------------------------------------------------------
module xml_tag_tokenizer
    import xtt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] char_in
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] byte_role, [4:3] tag_kind, [5] text_end, [6] tag_name_end,
    // [7] attr_name_end, [8] attr_value_end, [9] tag_done, [10] self_closing,
    // [42:11] byte_position, [47:43] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // input_end
    output logic                  m_axis_tlast
);

    logic                     r_in_valid;
    logic [7:0]               r_char;
    t_ctx                     r_ctx;
    t_ctx                     n_ctx;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic                     r_out_valid;
    t_result                  r_res;
    t_result                  n_res;
    logic [POS_OUT_W-1:0]     r_out_pos;
    logic                     w_advance;

    // A byte moves on when the result register is free or being drained.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_char <= s_axis_tdata[7:0];
        end
    end

    xtt_step u_step (
        .i_char (r_char),
        .i_ctx  (r_ctx),
        .o_ctx  (n_ctx),
        .o_res  (n_res)
    );

    // Saturating position; a terminating zero restarts it.
    always_comb begin
        if (r_char == CH_NUL) begin
            n_pos = '0;
        end else if (r_pos != {POSITION_BITS{1'b1}}) begin
            n_pos = r_pos + 1'b1;
        end else begin
            n_pos = r_pos;
        end
    end

    // Tokenizer context and position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state        <= ST_DATA;
            r_ctx.text_pending <= 1'b0;
            r_ctx.kind         <= KIND_NONE;
            r_pos              <= '0;
        end else if (w_advance) begin
            r_ctx <= n_ctx;
            r_pos <= n_pos;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_res     <= n_res;
            r_out_pos <= POS_OUT_W'(r_pos);
        end
    end

    // Output packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_res.input_end;
    assign m_axis_tdata  = {
        {(OUT_DATA_W - OB_POS_HI - 1){1'b0}},
        r_out_pos,
        r_res.self_closing,
        r_res.tag_done,
        r_res.attr_value_end,
        r_res.attr_name_end,
        r_res.tag_name_end,
        r_res.text_end,
        r_res.kind,
        r_res.role
    };

endmodule

>>> hdl/xtt_checker.sv
// ----------------------------------------------------------------------------
// xtt_checker
// Port-level checks for the tag tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module xtt_checker
    import xtt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // A result that is not taken stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The self-closing flag only comes with a completed tag.
    a_sc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OB_SELF_CL] |-> m_axis_tdata[OB_TAG_DONE])
        else $error("self_closing without tag_done");

    // The terminating byte is markup with no tag and no tag boundary.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[OB_KIND_HI:OB_ROLE_LO] == '0 &&
            m_axis_tdata[OB_SELF_CL:OB_NAME_END] == '0)
        else $error("end of input carries tag information");

    // With the result register empty the input side is always ready.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    // Nothing leaves the block right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind xml_tag_tokenizer xtt_checker u_xtt_checker (.*);

>>> sim/xml_tag_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// xml_tag_tokenizer_tb
// Self-checking testbench for the byte-serial XML tag tokenizer. A short table
// of markup bytes walks special cases and each state but ST_AFTER_ATTR and
// ST_VALUE_DQ. Random markup follows, mostly well-formed tags, text and
// skipped sections, mixed with noise and broken tags. A predictor in the
// testbench tracks the tokenizer context for every accepted byte. Each result
// is checked field by field against the oldest expected token. Both stream
// sides stall at random; the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module xml_tag_tokenizer_tb
    import xtt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Bytes that only the stimulus needs.
    localparam logic [7:0] CH_AMP = 8'h26;

    // Flag bits of a token, in field order from text_end down to input_end.
    localparam logic [6:0] F_TEXT_END  = 7'b1000000;
    localparam logic [6:0] F_NAME_END  = 7'b0100000;
    localparam logic [6:0] F_ANAME_END = 7'b0010000;
    localparam logic [6:0] F_VALUE_END = 7'b0001000;
    localparam logic [6:0] F_TAG_DONE  = 7'b0000100;
    localparam logic [6:0] F_SELF_CL   = 7'b0000010;
    localparam logic [6:0] F_IN_END    = 7'b0000001;

    // One token reported for one byte.
    typedef struct packed {
        t_role       role;
        t_kind       kind;
        logic        text_end;
        logic        tag_name_end;
        logic        attr_name_end;
        logic        attr_value_end;
        logic        tag_done;
        logic        self_closing;
        logic        input_end;
        logic [31:0] pos;
    } t_tok_out;

    // One row of the directed table; the token is used only where typed is set.
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        t_role       role;
        t_kind       kind;
        logic [6:0]  flags;
        logic [31:0] pos;
    } t_tok_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Predicted tokenizer context.
    t_state      pst = ST_DATA;
    logic        txt_pend = 1'b0;
    t_kind       cur_kind = KIND_NONE;
    logic [31:0] pos_cnt = '0;

    t_tok_out    tokens_due[$];
    int unsigned bytes_sent = 0;
    int unsigned n_errors = 0;

    // Directed walk: text with an ampersand, a start tag with a bad unquoted
    // value, a single-quoted value with an extreme byte, a self-closing end, an
    // end tag, both skipped markup forms and two stream ends in a row.
    t_tok_row dir_tab [28] = '{
        '{8'h61, 1'b1, ROLE_TEXT,   KIND_NONE,  7'b0, 32'd0},
        '{CH_AMP, 1'b1, ROLE_TEXT,  KIND_NONE,  7'b0, 32'd1},
        '{CH_LT, 1'b1, ROLE_MARKUP, KIND_NONE,  F_TEXT_END, 32'd2},
        '{8'h70, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_SPACE, 1'b0, ROLE_MARKUP, KIND_NONE, 7'b0, 32'd0},
        '{8'h78, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_EQ, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{8'h71, 1'b1, ROLE_MARKUP, KIND_START, 7'b0, 32'd7},
        '{8'h79, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_EQ, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_SQUOTE, 1'b0, ROLE_MARKUP, KIND_NONE, 7'b0, 32'd0},
        '{8'hFF, 1'b1, ROLE_AVALUE, KIND_START, 7'b0, 32'd11},
        '{CH_SQUOTE, 1'b0, ROLE_MARKUP, KIND_NONE, 7'b0, 32'd0},
        '{CH_SLASH, 1'b0, ROLE_MARKUP, KIND_NONE, 7'b0, 32'd0},
        '{CH_GT, 1'b1, ROLE_MARKUP, KIND_START, F_TAG_DONE | F_SELF_CL, 32'd14},
        '{CH_LT, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_SLASH, 1'b0, ROLE_MARKUP, KIND_NONE, 7'b0, 32'd0},
        '{8'h5A, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_GT, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_LT, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_BANG, 1'b0, ROLE_MARKUP, KIND_NONE, 7'b0, 32'd0},
        '{CH_GT, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_LT, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_QUEST, 1'b0, ROLE_MARKUP, KIND_NONE, 7'b0, 32'd0},
        '{CH_GT, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{8'h7F, 1'b0, ROLE_MARKUP, KIND_NONE,  7'b0, 32'd0},
        '{CH_NUL, 1'b1, ROLE_MARKUP, KIND_NONE, F_TEXT_END | F_IN_END, 32'd26},
        '{CH_NUL, 1'b1, ROLE_MARKUP, KIND_NONE, F_IN_END, 32'd0}
    };

    xml_tag_tokenizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic ws_byte(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR;
    endfunction

    function automatic logic alpha_byte(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    endfunction

    // Advance the predicted context by one byte and return its token.
    function automatic t_tok_out predict_byte(input logic [7:0] ch);
        t_tok_out r;
        t_state nx;
        r = '0;
        r.pos = pos_cnt;
        nx = pst;
        // A zero byte ends the stream and clears the whole context.
        if (ch == CH_NUL) begin
            r.text_end = txt_pend;
            r.input_end = 1'b1;
            pst = ST_DATA;
            txt_pend = 1'b0;
            cur_kind = KIND_NONE;
            pos_cnt = '0;
            return r;
        end
        case (pst)
            ST_TAG_OPEN: begin
                if (ch == CH_BANG || ch == CH_QUEST) nx = ST_SKIP;
                else if (ch == CH_SLASH) nx = ST_END_TAG_OPEN;
                else if (alpha_byte(ch)) begin
                    cur_kind = KIND_START;
                    r.role = ROLE_TAG;
                    nx = ST_TAG_NAME;
                end else nx = ST_DATA;
            end
            ST_END_TAG_OPEN: begin
                if (alpha_byte(ch)) begin
                    cur_kind = KIND_END;
                    r.role = ROLE_TAG;
                    nx = ST_TAG_NAME;
                end else if (ch == CH_GT) nx = ST_DATA;
            end
            ST_SKIP: begin
                if (ch == CH_GT) nx = ST_DATA;
            end
            ST_TAG_NAME: begin
                if (ws_byte(ch)) begin
                    r.tag_name_end = 1'b1;
                    nx = ST_BEFORE_ATTR;
                end else if (ch == CH_SLASH) begin
                    r.tag_name_end = 1'b1;
                    nx = ST_SELF_CLOSE;
                end else if (ch == CH_GT) begin
                    r.tag_name_end = 1'b1;
                    r.tag_done = 1'b1;
                end else r.role = ROLE_TAG;
            end
            ST_SELF_CLOSE: begin
                if (ch == CH_GT) begin
                    r.tag_done = 1'b1;
                    r.self_closing = 1'b1;
                end else nx = ST_BEFORE_ATTR;
            end
            ST_BEFORE_ATTR: begin
                if (ch == CH_SLASH) nx = ST_SELF_CLOSE;
                else if (ch == CH_GT) r.tag_done = 1'b1;
                else if (alpha_byte(ch)) begin
                    r.role = ROLE_ANAME;
                    nx = ST_ATTR_NAME;
                end
            end
            ST_ATTR_NAME: begin
                if (ws_byte(ch)) begin
                    r.attr_name_end = 1'b1;
                    nx = ST_AFTER_ATTR;
                end else if (ch == CH_SLASH) begin
                    r.attr_name_end = 1'b1;
                    nx = ST_SELF_CLOSE;
                end else if (ch == CH_EQ) begin
                    r.attr_name_end = 1'b1;
                    nx = ST_BEFORE_VALUE;
                end else if (ch == CH_GT) begin
                    r.attr_name_end = 1'b1;
                    r.tag_done = 1'b1;
                end else r.role = ROLE_ANAME;
            end
            ST_AFTER_ATTR: begin
                if (ch == CH_SLASH) nx = ST_SELF_CLOSE;
                else if (ch == CH_EQ) nx = ST_BEFORE_VALUE;
                else if (ch == CH_GT) r.tag_done = 1'b1;
                else if (alpha_byte(ch)) begin
                    r.role = ROLE_ANAME;
                    nx = ST_ATTR_NAME;
                end
            end
            ST_BEFORE_VALUE: begin
                // An unquoted value byte is a parse error back to the attributes.
                if (ws_byte(ch)) nx = ST_BEFORE_VALUE;
                else if (ch == CH_DQUOTE) nx = ST_VALUE_DQ;
                else if (ch == CH_SQUOTE) nx = ST_VALUE_SQ;
                else if (ch == CH_GT) r.tag_done = 1'b1;
                else nx = ST_BEFORE_ATTR;
            end
            ST_VALUE_DQ: begin
                if (ch == CH_DQUOTE) begin
                    r.attr_value_end = 1'b1;
                    nx = ST_AFTER_VALUE;
                end else r.role = ROLE_AVALUE;
            end
            ST_VALUE_SQ: begin
                if (ch == CH_SQUOTE) begin
                    r.attr_value_end = 1'b1;
                    nx = ST_AFTER_VALUE;
                end else r.role = ROLE_AVALUE;
            end
            ST_AFTER_VALUE: begin
                if (ch == CH_SLASH) nx = ST_SELF_CLOSE;
                else if (ch == CH_GT) r.tag_done = 1'b1;
                else nx = ST_BEFORE_ATTR;
            end
            default: begin
                if (ch == CH_LT) begin
                    r.text_end = txt_pend;
                    txt_pend = 1'b0;
                    nx = ST_TAG_OPEN;
                end else begin
                    r.role = ROLE_TEXT;
                    txt_pend = 1'b1;
                    nx = ST_DATA;
                end
            end
        endcase
        // The finished tag is reported before its kind is cleared.
        r.kind = cur_kind;
        if (r.tag_done) begin
            nx = ST_DATA;
            cur_kind = KIND_NONE;
        end
        pst = nx;
        if (pos_cnt != '1) pos_cnt = pos_cnt + 1'b1;
        return r;
    endfunction

    // Offer one byte as a request, with random gaps outside the calm window.
    task automatic offer_byte(input logic [7:0] ch, input logic typed, input t_tok_out want);
        t_tok_out model;
        if (bytes_sent < 800 || bytes_sent >= 1100) begin
            while ($urandom_range(99) < 36) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        model = predict_byte(ch);
        tokens_due.push_back(typed ? want : model);
        bytes_sent++;
    endtask

    task automatic put(input logic [7:0] ch);
        offer_byte(ch, 1'b0, '0);
    endtask

    // Random nonzero byte that differs from the given delimiter.
    function automatic logic [7:0] rand_byte_not(input logic [7:0] delim);
        logic [7:0] ch;
        do ch = 8'($urandom_range(1, 255)); while (ch == delim);
        return ch;
    endfunction

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    // A name: a letter, then letters with an occasional digit, dash or colon.
    task automatic gen_name();
        put(rand_letter());
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 9))
                0: put(8'h30 + 8'($urandom_range(0, 9)));
                1: put($urandom_range(0, 1) ? 8'h2D : 8'h3A);
                default: put(rand_letter());
            endcase
        end
    endtask

    // One random fragment of markup: mostly well formed, some noise.
    task automatic gen_fragment();
        logic [7:0] q;
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        case ($urandom_range(0, 99)) inside
            [0:19]: begin
                repeat ($urandom_range(1, 8)) put(rand_byte_not(CH_LT));
                if ($urandom_range(0, 3) == 0) put(CH_AMP);
            end
            [20:52]: begin
                put(CH_LT);
                gen_name();
                repeat ($urandom_range(0, 3)) begin
                    put(rand_ws());
                    gen_name();
                    case ($urandom_range(0, 3))
                        0: ;
                        1, 2: begin
                            put(CH_EQ);
                            put(q);
                            repeat ($urandom_range(0, 6)) put(rand_byte_not(q));
                            put(q);
                        end
                        default: begin
                            put(rand_ws());
                            put(CH_EQ);
                            put(rand_ws());
                            put(q);
                            repeat ($urandom_range(0, 3)) put(rand_byte_not(q));
                            put(q);
                        end
                    endcase
                end
                if ($urandom_range(0, 3) == 0) put(rand_ws());
                if ($urandom_range(0, 3) == 0) put(CH_SLASH);
                put(CH_GT);
            end
            [53:64]: begin
                put(CH_LT);
                put(CH_SLASH);
                gen_name();
                if ($urandom_range(0, 3) == 0) put(rand_ws());
                put(CH_GT);
            end
            [65:72]: begin
                put(CH_LT);
                put($urandom_range(0, 1) ? CH_BANG : CH_QUEST);
                repeat ($urandom_range(0, 6)) put(rand_byte_not(CH_GT));
                put(CH_GT);
            end
            [73:86]: begin
                repeat ($urandom_range(1, 4)) put(8'($urandom_range(1, 255)));
            end
            [87:95]: begin
                // Broken tag: random tag bytes and no proper close.
                put(CH_LT);
                if ($urandom_range(0, 1)) put(CH_SLASH);
                if ($urandom_range(0, 1)) gen_name();
                repeat ($urandom_range(1, 5)) begin
                    case ($urandom_range(0, 6))
                        0: put(CH_EQ);
                        1: put(CH_SLASH);
                        2: put(q);
                        3: put(rand_ws());
                        4: put(rand_letter());
                        5: put(CH_GT);
                        default: put(8'($urandom_range(1, 255)));
                    endcase
                end
            end
            default: put(CH_NUL);
        endcase
    endtask

    // Compare one received token with its prediction, field by field.
    task automatic compare_token(input t_tok_out got, input t_tok_out want);
        if (got.role != want.role) begin
            $error("byte_role: expected %0d, got %0d", want.role, got.role);
            n_errors++;
        end
        if (got.kind != want.kind) begin
            $error("tag_kind: expected %0d, got %0d", want.kind, got.kind);
            n_errors++;
        end
        if (got.text_end != want.text_end) begin
            $error("text_end: expected %0d, got %0d", want.text_end, got.text_end);
            n_errors++;
        end
        if (got.tag_name_end != want.tag_name_end) begin
            $error("tag_name_end: expected %0d, got %0d", want.tag_name_end, got.tag_name_end);
            n_errors++;
        end
        if (got.attr_name_end != want.attr_name_end) begin
            $error("attr_name_end: expected %0d, got %0d",
                   want.attr_name_end, got.attr_name_end);
            n_errors++;
        end
        if (got.attr_value_end != want.attr_value_end) begin
            $error("attr_value_end: expected %0d, got %0d",
                   want.attr_value_end, got.attr_value_end);
            n_errors++;
        end
        if (got.tag_done != want.tag_done) begin
            $error("tag_done: expected %0d, got %0d", want.tag_done, got.tag_done);
            n_errors++;
        end
        if (got.self_closing != want.self_closing) begin
            $error("self_closing: expected %0d, got %0d", want.self_closing, got.self_closing);
            n_errors++;
        end
        if (got.input_end != want.input_end) begin
            $error("input_end: expected %0d, got %0d", want.input_end, got.input_end);
            n_errors++;
        end
        if (got.pos != want.pos) begin
            $error("byte_position: expected %0d, got %0d", want.pos, got.pos);
            n_errors++;
        end
    endtask

    // Check every result request that the output side accepts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tokens_due.size() == 0) begin
                $error("result with no token expected: tdata %h", m_axis_tdata);
                n_errors++;
            end else begin
                compare_token(t_tok_out'({m_axis_tdata[OB_ROLE_HI:OB_ROLE_LO],
                                          m_axis_tdata[OB_KIND_HI:OB_KIND_LO],
                                          m_axis_tdata[OB_TEXT_END],
                                          m_axis_tdata[OB_NAME_END],
                                          m_axis_tdata[OB_ANAME_END],
                                          m_axis_tdata[OB_VALUE_END],
                                          m_axis_tdata[OB_TAG_DONE],
                                          m_axis_tdata[OB_SELF_CL],
                                          m_axis_tlast,
                                          m_axis_tdata[OB_POS_HI:OB_POS_LO]}),
                              tokens_due.pop_front());
            end
        end
    end

    // Output side: random stalls, one long hold-off, one calm window.
    initial begin
        int unsigned cyc = 0;
        int unsigned hold = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 400) hold = 120;
            if (hold != 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (cyc >= 2000 && cyc < 2600) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 36);
            end
        end
    end

    // Reset, directed table, random markup, then drain and report.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_tab[i]) begin
            offer_byte(dir_tab[i].ch, dir_tab[i].typed,
                       t_tok_out'({dir_tab[i].role, dir_tab[i].kind,
                                   dir_tab[i].flags, dir_tab[i].pos}));
        end
        while (bytes_sent < 1900) gen_fragment();
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tokens_due.size() != 0) begin
            $error("%0d tokens never arrived", tokens_due.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("xml_tag_tokenizer: match");
        end else begin
            $display("xml_tag_tokenizer: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("xml_tag_tokenizer: mismatch");
        $finish;
    end

endmodule

>>> files.f
hdl/xtt_pkg.sv
hdl/xtt_step.sv
hdl/xml_tag_tokenizer.sv
hdl/xtt_checker.sv
sim/xml_tag_tokenizer_tb.sv
